// ===== rtl/smfe_pkg.sv =====
// ----------------------------------------------------------------------------
// smfe_pkg
// Shared types, codes and constants of the freshness counter and MAC engine.
// ----------------------------------------------------------------------------
package smfe_pkg;

  localparam int unsigned MAC_BYTES = 4;
  localparam logic [31:0] MAC_MASK = (MAC_BYTES >= 4) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << (8 * MAC_BYTES)) - 64'd1);

  localparam logic [63:0] GOLDEN_MUL = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [15:0] WINDOW_RESET = 16'd10;

  // absorb sequence: 16 key bytes, 4 freshness bytes, then the payload byte
  localparam logic [4:0] LAST_PRE_STEP = 5'd19;
  localparam logic [4:0] DATA_STEP     = 5'd20;

  typedef enum logic [1:0] {
    REQ_AUTH   = 2'd0,
    REQ_VERIFY = 2'd1,
    REQ_SYNC   = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_MISMATCH = 2'd1,
    STS_REPLAY   = 2'd2,
    STS_WINDOW   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_WINDOW   = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    PH_LO      = 2'd0,
    PH_CROSS_A = 2'd1,
    PH_CROSS_B = 2'd2
  } mul_phase_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        first;
    logic        last;
    logic [31:0] msg_freshness;
    logic [31:0] received_mac;
    logic [31:0] sync_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        was_verify;
    logic [31:0] mac_out;
    logic [31:0] freshness_used;
  } res_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [63:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic       latch;
    logic       sync;
    logic       start;
    logic       absorb;
    mul_phase_e phase;
    logic [4:0] step;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic has_byte;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/smfe_if.sv =====
// ----------------------------------------------------------------------------
// smfe_if
// Valid/ready channels of the engine: request, result and configuration.
// ----------------------------------------------------------------------------
interface smfe_req_if;
  logic          valid;
  logic          ready;
  smfe_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface smfe_res_if;
  logic          valid;
  logic          ready;
  smfe_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface smfe_cfg_if;
  logic          valid;
  logic          ready;
  smfe_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/smfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// smfe_ctrl
// Sequencer: accepts requests, steps the absorb schedule and multiply phases,
// and issues the result write.
// ----------------------------------------------------------------------------
module smfe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  smfe_pkg::req_t req_data_i,
  output logic           req_ready_o,
  input  smfe_pkg::sts_t sts_i,
  output smfe_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_RESULT
  } state_e;

  state_e               state_q;
  smfe_pkg::mul_phase_e phase_q;
  logic [4:0]           step_q;
  logic                 accept;
  logic                 msg_req;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign msg_req     = (req_data_i.req_type == smfe_pkg::REQ_AUTH) ||
                       (req_data_i.req_type == smfe_pkg::REQ_VERIFY);

  always_comb begin
    cmd_o        = '0;
    cmd_o.phase  = phase_q;
    cmd_o.step   = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.latch = msg_req;
          cmd_o.start = msg_req && req_data_i.first;
          cmd_o.sync  = (req_data_i.req_type == smfe_pkg::REQ_SYNC);
        end
      end
      ST_ABSORB: cmd_o.absorb = 1'b1;
      ST_RESULT: cmd_o.finish = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= smfe_pkg::PH_LO;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && msg_req) begin
            phase_q <= smfe_pkg::PH_LO;
            if (req_data_i.first) begin
              step_q  <= '0;
              state_q <= ST_ABSORB;
            end else if (req_data_i.has_byte) begin
              step_q  <= smfe_pkg::DATA_STEP;
              state_q <= ST_ABSORB;
            end else if (req_data_i.last) begin
              state_q <= ST_RESULT;
            end
          end
        end
        ST_ABSORB: begin
          unique case (phase_q)
            smfe_pkg::PH_LO:      phase_q <= smfe_pkg::PH_CROSS_A;
            smfe_pkg::PH_CROSS_A: phase_q <= smfe_pkg::PH_CROSS_B;
            default: begin
              phase_q <= smfe_pkg::PH_LO;
              if (step_q == smfe_pkg::DATA_STEP) begin
                state_q <= sts_i.last ? ST_RESULT : ST_IDLE;
              end else if (step_q == smfe_pkg::LAST_PRE_STEP) begin
                if (sts_i.has_byte) begin
                  step_q <= smfe_pkg::DATA_STEP;
                end else begin
                  state_q <= sts_i.last ? ST_RESULT : ST_IDLE;
                end
              end else begin
                step_q <= step_q + 5'd1;
              end
            end
          endcase
        end
        ST_RESULT: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/smfe_datapath.sv =====
// ----------------------------------------------------------------------------
// smfe_datapath
// Key and window registers, counters, hash with a shared 32x32 multiplier,
// verify checks and the result register.
// ----------------------------------------------------------------------------
module smfe_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  smfe_pkg::cfg_t cfg_data_i,
  input  smfe_pkg::req_t req_data_i,
  input  smfe_pkg::cmd_t cmd_i,
  output smfe_pkg::sts_t sts_o,
  input  logic           res_ready_i,
  output logic           res_valid_o,
  output smfe_pkg::res_t res_data_o
);

  logic [63:0] key_high_q;
  logic [63:0] key_low_q;
  logic [15:0] window_q;
  logic [63:0] hash_q, hash_d;
  logic [31:0] tx_q, tx_d;
  logic [31:0] rx_q, rx_d;
  logic [31:0] fresh_q, fresh_d;
  logic        mode_q, mode_d;
  logic [63:0] x_q, x_d;
  logic [63:0] prod_q, prod_d;
  logic [7:0]  byte_q;
  logic        has_q;
  logic        last_q;
  logic [31:0] rmac_q;
  logic        res_valid_q, res_valid_d;
  smfe_pkg::res_t res_q, res_d;

  logic [159:0] pre_bytes;
  logic [7:0]   pre_idx;
  logic [7:0]   absorb_byte;
  logic [63:0]  x_comb;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic [31:0]  hi_new;
  logic [31:0]  mac;
  logic [31:0]  limit;
  logic [31:0]  tx_inc;

  assign pre_bytes   = {key_high_q, key_low_q, fresh_q};
  assign pre_idx     = 8'd159 - {cmd_i.step, 3'b000};
  assign absorb_byte = (cmd_i.step == smfe_pkg::DATA_STEP) ? byte_q : pre_bytes[pre_idx -: 8];
  assign x_comb      = hash_q ^ {56'd0, absorb_byte};

  always_comb begin
    unique case (cmd_i.phase)
      smfe_pkg::PH_LO: begin
        mul_a = x_comb[31:0];
        mul_b = smfe_pkg::GOLDEN_MUL[31:0];
      end
      smfe_pkg::PH_CROSS_A: begin
        mul_a = x_q[31:0];
        mul_b = smfe_pkg::GOLDEN_MUL[63:32];
      end
      default: begin
        mul_a = x_q[63:32];
        mul_b = smfe_pkg::GOLDEN_MUL[31:0];
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign hi_new = prod_q[63:32] + mul_p[31:0];
  assign mac    = hash_q[31:0] & smfe_pkg::MAC_MASK;
  assign limit  = rx_q + {16'd0, window_q};
  assign tx_inc = tx_q + 32'd1;

  always_comb begin
    hash_d      = hash_q;
    tx_d        = tx_q;
    rx_d        = rx_q;
    fresh_d     = fresh_q;
    mode_d      = mode_q;
    x_d         = x_q;
    prod_d      = prod_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;

    if (cmd_i.sync) begin
      tx_d = req_data_i.sync_value;
      rx_d = req_data_i.sync_value;
    end

    if (cmd_i.start) begin
      mode_d = req_data_i.req_type[0];
      hash_d = '0;
      if (req_data_i.req_type == smfe_pkg::REQ_AUTH) begin
        tx_d    = tx_inc;
        fresh_d = tx_inc;
      end else begin
        fresh_d = req_data_i.msg_freshness;
      end
    end

    if (cmd_i.absorb) begin
      unique case (cmd_i.phase)
        smfe_pkg::PH_LO: begin
          x_d    = x_comb;
          prod_d = mul_p;
        end
        smfe_pkg::PH_CROSS_A: begin
          prod_d = {hi_new, prod_q[31:0]};
        end
        default: begin
          hash_d = {hi_new, prod_q[31:0] ^ hi_new};
        end
      endcase
    end

    if (cmd_i.finish) begin
      res_valid_d          = 1'b1;
      res_d.was_verify     = mode_q;
      res_d.mac_out        = mac;
      res_d.freshness_used = fresh_q;
      res_d.status         = smfe_pkg::STS_OK;
      if (mode_q) begin
        if (fresh_q <= rx_q) begin
          res_d.status = smfe_pkg::STS_REPLAY;
        end else if (fresh_q > limit) begin
          res_d.status = smfe_pkg::STS_WINDOW;
        end else if ((rmac_q & smfe_pkg::MAC_MASK) != mac) begin
          res_d.status = smfe_pkg::STS_MISMATCH;
        end else begin
          rx_d = fresh_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q  <= '0;
      key_low_q   <= '0;
      window_q    <= smfe_pkg::WINDOW_RESET;
      hash_q      <= '0;
      tx_q        <= '0;
      rx_q        <= '0;
      fresh_q     <= '0;
      mode_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_data_i.index)
          smfe_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data_i.wdata;
          smfe_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data_i.wdata;
          smfe_pkg::CFG_WINDOW:   window_q   <= cfg_data_i.wdata[15:0];
          default: ;
        endcase
      end
      hash_q      <= hash_d;
      tx_q        <= tx_d;
      rx_q        <= rx_d;
      fresh_q     <= fresh_d;
      mode_q      <= mode_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    prod_q <= prod_d;
    res_q  <= res_d;
    if (cmd_i.latch) begin
      byte_q <= req_data_i.data_byte;
      has_q  <= req_data_i.has_byte;
      last_q <= req_data_i.last;
      rmac_q <= req_data_i.received_mac;
    end
  end

  assign sts_o.has_byte = has_q;
  assign sts_o.last     = last_q;
  assign sts_o.out_free = !res_valid_q || res_ready_i;
  assign res_valid_o    = res_valid_q;
  assign res_data_o     = res_q;

endmodule

// ===== rtl/secoc_mac_freshness_engine_top.sv =====
// ----------------------------------------------------------------------------
// secoc_mac_freshness_engine_top
// Freshness counter and truncated MAC engine for transmit authentication and
// receive verification.
// ----------------------------------------------------------------------------
// One request transaction is taken at a time. Each absorbed byte passes
// through three phases on the single shared 32x32 multiplier (low product,
// then the two cross products). A first item absorbs 16 key bytes and 4
// freshness bytes before its payload byte, if it has one. A later item
// absorbs only its payload byte, if it has one. A last item then writes the
// result register, which waits while an earlier result is still held. Sync
// and unused request codes do not enter the absorb sequence. Configuration
// transactions are always accepted.
module secoc_mac_freshness_engine_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  smfe_req_if.sink         req_i,
  smfe_res_if.source       res_o,
  smfe_cfg_if.sink         cfg_i
);

  smfe_pkg::cmd_t cmd;
  smfe_pkg::sts_t sts;
  logic           req_ready;

  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  smfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_data_i  (req_i.data),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smfe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .req_data_i  (req_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .res_data_o  (res_o.data)
  );

endmodule
